// File: rtl/dual_fifo_pcm_sound_channel_defines.svh
// ----------------------------------------------------------------------------
// dual_fifo_pcm_sound_channel_defines.svh
// assertion macros shared by the sound channel rtl
// ----------------------------------------------------------------------------
`ifndef DUAL_FIFO_PCM_SOUND_CHANNEL_DEFINES_SVH
`define DUAL_FIFO_PCM_SOUND_CHANNEL_DEFINES_SVH

// condition holds on every edge outside reset
`define DFP_ASSERT_HOLDS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define DFP_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: rtl/dfp_pkg.sv
// ----------------------------------------------------------------------------
// dfp_pkg
// types and constants of the two channel pcm sound block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dfp_pkg;

  localparam int DEFAULT_FIFO_DEPTH   = 256;
  localparam int DEFAULT_NUM_CHANNELS = 2;

  localparam int SAMPLE_W   = 8;
  localparam int PERIOD_W   = 12;
  localparam int VOLUME_W   = 4;
  localparam int PHASE_W    = 4;
  localparam int REQ_W      = 2;
  localparam int CHANNEL_W  = 1;
  localparam int ADDR_W     = 2;
  localparam int AUDIO_W    = 16;
  localparam int LVL_KIND_W = 2;

  // request types
  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd2;

  // register addresses
  localparam logic [ADDR_W-1:0] REG_RESET     = 2'd0;
  localparam logic [ADDR_W-1:0] REG_PUSH      = 2'd1;
  localparam logic [ADDR_W-1:0] REG_PERIOD_LO = 2'd2;
  localparam logic [ADDR_W-1:0] REG_PERIOD_HI = 2'd3;

  // how the level of a channel changes in the second stage
  localparam logic [LVL_KIND_W-1:0] LVL_KEEP  = 2'd0;
  localparam logic [LVL_KIND_W-1:0] LVL_MEM   = 2'd1;
  localparam logic [LVL_KIND_W-1:0] LVL_SET   = 2'd2;
  localparam logic [LVL_KIND_W-1:0] LVL_CLEAR = 2'd3;

  localparam logic [SAMPLE_W-1:0] SIGN_FLIP = 8'h80;

  localparam int STATUS_FULL_BIT  = 7;
  localparam int STATUS_EMPTY_BIT = 6;

  // the mix of the levels is scaled by 128
  localparam int MIX_SHIFT = 7;
  localparam int AUDIO_MAX = 32767;
  localparam int AUDIO_MIN = -32768;

endpackage

`default_nettype wire

// File: rtl/dual_fifo_pcm_sound_channel.sv
// ----------------------------------------------------------------------------
// dual_fifo_pcm_sound_channel
// pcm sound channels, each fed from a byte fifo, mixed once per tick
// ----------------------------------------------------------------------------
// Requests enter on cmd_valid / cmd_stall with req_type, channel, reg_addr
// and write_data; each request yields exactly one result on res_valid /
// res_stall carrying read_data and audio_sample.
// A register write gives an all zero result, a status read returns full in
// bit 7 and empty in bit 6, a tick steps every channel that is not empty and returns the mix.
// Throughput is one request per cycle while res_stall is low. A taken request
// passes a first stage that updates the channel state and reads the
// sample ram of each channel, and a second that picks up the read data, forms the new
// levels and the mix into the output register.
// Each channel keeps its fifo in its own ram, so a tick reads all channels
// in the same cycle. A fill count per channel marks which entries were
// written since the last clear, so reset and the channel reset register
// take effect at once, with no clearing pass over the ram.
// When res_stall is high the result and the request in flight hold, and
// cmd_stall rises once both stages are occupied.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "dual_fifo_pcm_sound_channel_defines.svh"

module dual_fifo_pcm_sound_channel
  import dfp_pkg::*;
#(
  parameter int FIFO_DEPTH   = DEFAULT_FIFO_DEPTH,
  parameter int NUM_CHANNELS = DEFAULT_NUM_CHANNELS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  output logic                       cmd_stall,
  input  logic [REQ_W-1:0]           req_type,
  input  logic [CHANNEL_W-1:0]       channel,
  input  logic [ADDR_W-1:0]          reg_addr,
  input  logic [SAMPLE_W-1:0]        write_data,
  output logic                       res_valid,
  input  logic                       res_stall,
  output logic [SAMPLE_W-1:0]        read_data,
  output logic signed [AUDIO_W-1:0]  audio_sample
);

  localparam int PTR_W       = $clog2(FIFO_DEPTH);
  localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);
  localparam int ADDRESSABLE = 1 << CHANNEL_W;
  localparam int SUM_W       = SAMPLE_W + $clog2(NUM_CHANNELS);
  localparam int SC_W        = SUM_W + MIX_SHIFT + 1;
  localparam logic signed [SC_W-1:0] SC_MAX = SC_W'(AUDIO_MAX);
  localparam logic signed [SC_W-1:0] SC_MIN = SC_W'(AUDIO_MIN);

  logic                    accept;
  logic                    s1_adv;
  logic                    s1_valid;
  logic [REQ_W-1:0]        s1_req;
  logic [SAMPLE_W-1:0]     s1_data;
  logic [SAMPLE_W-1:0]     s1_status;
  logic [SAMPLE_W-1:0]     status_next;
  logic [PHASE_W-1:0]      phase;
  logic [PHASE_W-1:0]      phase_next;
  logic                    is_tick;
  logic                    is_write;

  logic [NUM_CHANNELS-1:0]               hit;
  logic [NUM_CHANNELS-1:0]               full_v;
  logic [NUM_CHANNELS-1:0]               empty_v;
  logic [NUM_CHANNELS-1:0]               gate_v;
  logic [NUM_CHANNELS-1:0][SAMPLE_W-1:0] lvl_next_v;

  logic signed [SUM_W-1:0] mix_sum;
  logic signed [SC_W-1:0]  mix_scaled;
  logic [AUDIO_W-1:0]      mix_sat;

  assign s1_adv    = s1_valid && (!res_valid || !res_stall);
  assign cmd_stall = s1_valid && !s1_adv;
  assign accept    = cmd_valid && !cmd_stall;
  assign is_tick   = (req_type == REQ_TICK);
  assign is_write  = (req_type == REQ_WRITE);
  assign phase_next = phase + PHASE_W'(1);

  // per channel state, sample ram and level update
  for (genvar k = 0; k < NUM_CHANNELS; k++) begin : g_ch
    logic [PTR_W-1:0]      rp, rp_next, rp_inc;
    logic [PTR_W-1:0]      wp, wp_next, wp_inc;
    logic [CNT_W-1:0]      hw, hw_next;
    logic                  full, full_next;
    logic                  empty, empty_next;
    logic [PERIOD_W-1:0]   period, period_next;
    logic [VOLUME_W-1:0]   vol, vol_next;
    logic [PERIOD_W-1:0]   cd, cd_next;
    logic [SAMPLE_W-1:0]   lvl, lvl_next, mem_lvl;
    logic [LVL_KIND_W-1:0] kind_next, s1_kind;
    logic                  s1_gate, s1_memok;
    logic                  re, we;
    logic [PTR_W-1:0]      raddr;
    logic [SAMPLE_W-1:0]   rdata;

    assign hit[k] = (k < ADDRESSABLE) && (channel == CHANNEL_W'(k));
    assign rp_inc = (rp == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rp + PTR_W'(1);
    assign wp_inc = (wp == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wp + PTR_W'(1);

    always_comb begin
      rp_next     = rp;
      wp_next     = wp;
      hw_next     = hw;
      full_next   = full;
      empty_next  = empty;
      period_next = period;
      vol_next    = vol;
      cd_next     = cd;
      kind_next   = LVL_KEEP;
      re          = 1'b0;
      we          = 1'b0;
      raddr       = rp;
      if (accept && is_write && hit[k]) begin
        case (reg_addr)
          REG_RESET: begin
            rp_next    = '0;
            wp_next    = '0;
            hw_next    = '0;
            full_next  = 1'b0;
            empty_next = 1'b1;
            cd_next    = period;
            kind_next  = LVL_CLEAR;
          end
          REG_PUSH: begin
            if (rp == wp) begin
              empty_next = 1'b0;
              cd_next    = period;
              kind_next  = LVL_SET;
            end
            we      = 1'b1;
            wp_next = wp_inc;
            if (rp == wp_inc) begin
              full_next = 1'b1;
            end
            if (hw != CNT_W'(FIFO_DEPTH)) begin
              hw_next = hw + CNT_W'(1);
            end
          end
          REG_PERIOD_LO: begin
            period_next = {period[PERIOD_W-1:SAMPLE_W], write_data};
          end
          REG_PERIOD_HI: begin
            period_next = {write_data[PERIOD_W-SAMPLE_W-1:0], period[SAMPLE_W-1:0]};
            vol_next    = write_data[SAMPLE_W-1:SAMPLE_W-VOLUME_W];
            if (!empty) begin
              re        = 1'b1;
              kind_next = LVL_MEM;
            end
          end
          default: begin
          end
        endcase
      end else if (accept && is_tick && !empty) begin
        if (cd == '0) begin
          cd_next = period;
          if (rp == wp) begin
            full_next = 1'b0;
          end
          rp_next   = rp_inc;
          raddr     = rp_inc;
          re        = 1'b1;
          kind_next = LVL_MEM;
          if (rp_inc == wp) begin
            empty_next = 1'b1;
          end
        end else begin
          cd_next = cd - PERIOD_W'(1);
        end
      end
    end

    dfp_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (FIFO_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr (wp),
      .wdata (write_data),
      .re    (re),
      .raddr (raddr),
      .rdata (rdata)
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        rp     <= '0;
        wp     <= '0;
        hw     <= '0;
        full   <= 1'b0;
        empty  <= 1'b1;
        period <= '0;
        vol    <= '0;
        cd     <= '0;
        lvl    <= '0;
      end else begin
        rp     <= rp_next;
        wp     <= wp_next;
        hw     <= hw_next;
        full   <= full_next;
        empty  <= empty_next;
        period <= period_next;
        vol    <= vol_next;
        cd     <= cd_next;
        if (s1_adv) begin
          lvl <= lvl_next;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (accept) begin
        s1_kind  <= kind_next;
        s1_gate  <= !empty && (vol >= phase_next);
        s1_memok <= (CNT_W'(raddr) < hw);
      end
    end

    // entries past the fill count read as zero
    assign mem_lvl = (s1_memok ? rdata : '0) ^ SIGN_FLIP;

    always_comb begin
      case (s1_kind)
        LVL_KEEP:  lvl_next = lvl;
        LVL_MEM:   lvl_next = mem_lvl;
        LVL_SET:   lvl_next = s1_data ^ SIGN_FLIP;
        LVL_CLEAR: lvl_next = '0;
        default:   lvl_next = lvl;
      endcase
    end

    assign full_v[k]     = full;
    assign empty_v[k]    = empty;
    assign gate_v[k]     = s1_gate;
    assign lvl_next_v[k] = lvl_next;

    `DFP_ASSERT_IMPLIES(a_full_written, clk, rst, full, hw == CNT_W'(FIFO_DEPTH), "full channel with unwritten entries")
    `DFP_ASSERT_IMPLIES(a_head_written, clk, rst, !empty, CNT_W'(rp) < hw, "fifo head past fill count")
  end

  always_comb begin
    status_next = '0;
    if (req_type == REQ_READ) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        if (hit[i]) begin
          status_next[STATUS_FULL_BIT]  = full_v[i];
          status_next[STATUS_EMPTY_BIT] = empty_v[i];
        end
      end
    end
  end

  always_comb begin
    mix_sum = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (gate_v[i]) begin
        mix_sum = mix_sum + SUM_W'($signed(lvl_next_v[i]));
      end
    end
    mix_scaled = SC_W'(mix_sum) <<< MIX_SHIFT;
    if (mix_scaled > SC_MAX) begin
      mix_sat = SC_MAX[AUDIO_W-1:0];
    end else if (mix_scaled < SC_MIN) begin
      mix_sat = SC_MIN[AUDIO_W-1:0];
    end else begin
      mix_sat = mix_scaled[AUDIO_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
      phase     <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      if (accept && is_tick) begin
        phase <= phase_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req    <= req_type;
      s1_data   <= write_data;
      s1_status <= status_next;
    end
    if (s1_adv) begin
      read_data    <= s1_status;
      audio_sample <= (s1_req == REQ_TICK) ? mix_sat : '0;
    end
  end

  `DFP_ASSERT_IMPLIES(a_stall_busy, clk, rst, cmd_stall, s1_valid && res_valid, "input stalled with room in the pipeline")
  `DFP_ASSERT_IMPLIES(a_one_result, clk, rst, res_valid, read_data == '0 || audio_sample == '0, "status and audio both set")

endmodule

`default_nettype wire

// File: rtl/dfp_ram.sv
// ----------------------------------------------------------------------------
// dfp_ram
// single port write, single port read ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
